// ----- design/ses_pkg.sv -----
// Shared types, constants and the microcode table of the encoder speed estimator.
package ses_pkg;

    // Field widths fixed by the interface
    localparam int POS_W     = 16;
    localparam int PULSE_W   = 16;
    localparam int SPEED_W   = 32;
    localparam int GAIN_W    = 32;
    localparam int THRESH_W  = 31;
    localparam int CPR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);

    // Glitch window is a quarter revolution
    localparam int WIN_W  = CPR_W - 2;
    localparam int KEPT_W = WIN_W + 3;

    // Smoothing: (new + 9 * old + 5) / 10
    localparam int SMOOTH_DIV = 10;
    localparam int ROUND_HALF = 5;

    // Shared serial divider
    localparam int DIV_W      = 52;
    localparam int DIVISOR_W  = PULSE_W;
    localparam int DIV_CNT_W  = 5;
    localparam int FNUM_W     = 36;
    localparam int PROD_W     = 50;

    typedef enum logic [1:0] {
        DIV_LEN_32 = 2'd0,
        DIV_LEN_36 = 2'd1,
        DIV_LEN_52 = 2'd2
    } div_len_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTS_PER_REV = 3'd0,
        REG_FIXED_GAIN     = 3'd1,
        REG_TIMED_GAIN     = 3'd2,
        REG_HIGH_THRESHOLD = 3'd3,
        REG_LOW_THRESHOLD  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_LOAD       = 4'd1,
        OP_DIV_RAW    = 4'd2,
        OP_FACTOR_NUM = 4'd3,
        OP_FACTOR_SET = 4'd4,
        OP_MUL        = 4'd5,
        OP_SPEED_NUM  = 4'd6,
        OP_SPEED_SET  = 4'd7,
        OP_EMIT       = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_NO_INPUT    = 3'd1,
        COND_SKIP_FACTOR = 3'd2,
        COND_DIV_BUSY    = 3'd3,
        COND_OUT_BLOCKED = 3'd4
    } cond_t;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_WAIT       = 4'd0;
    localparam logic [STEP_W-1:0] ST_BRANCH     = 4'd1;
    localparam logic [STEP_W-1:0] ST_DIV_RAW    = 4'd2;
    localparam logic [STEP_W-1:0] ST_RAW_RUN    = 4'd3;
    localparam logic [STEP_W-1:0] ST_FACTOR_NUM = 4'd4;
    localparam logic [STEP_W-1:0] ST_FACTOR_RUN = 4'd5;
    localparam logic [STEP_W-1:0] ST_FACTOR_SET = 4'd6;
    localparam logic [STEP_W-1:0] ST_MUL        = 4'd7;
    localparam logic [STEP_W-1:0] ST_SPEED_NUM  = 4'd8;
    localparam logic [STEP_W-1:0] ST_SPEED_RUN  = 4'd9;
    localparam logic [STEP_W-1:0] ST_SPEED_SET  = 4'd10;
    localparam logic [STEP_W-1:0] ST_EMIT       = 4'd11;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic skip_factor;
        logic div_busy;
        logic out_blocked;
    } status_t;

    // Control store: jump to target on condition, else advance or, if last, wait
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            case (step)
                ST_WAIT:       w = '{OP_LOAD,       COND_NO_INPUT,    ST_WAIT,       1'b0};
                ST_BRANCH:     w = '{OP_NOP,        COND_SKIP_FACTOR, ST_MUL,        1'b0};
                ST_DIV_RAW:    w = '{OP_DIV_RAW,    COND_NEVER,       ST_WAIT,       1'b0};
                ST_RAW_RUN:    w = '{OP_NOP,        COND_DIV_BUSY,    ST_RAW_RUN,    1'b0};
                ST_FACTOR_NUM: w = '{OP_FACTOR_NUM, COND_NEVER,       ST_WAIT,       1'b0};
                ST_FACTOR_RUN: w = '{OP_NOP,        COND_DIV_BUSY,    ST_FACTOR_RUN, 1'b0};
                ST_FACTOR_SET: w = '{OP_FACTOR_SET, COND_NEVER,       ST_WAIT,       1'b0};
                ST_MUL:        w = '{OP_MUL,        COND_NEVER,       ST_WAIT,       1'b0};
                ST_SPEED_NUM:  w = '{OP_SPEED_NUM,  COND_NEVER,       ST_WAIT,       1'b0};
                ST_SPEED_RUN:  w = '{OP_NOP,        COND_DIV_BUSY,    ST_SPEED_RUN,  1'b0};
                ST_SPEED_SET:  w = '{OP_SPEED_SET,  COND_NEVER,       ST_WAIT,       1'b0};
                ST_EMIT:       w = '{OP_EMIT,       COND_OUT_BLOCKED, ST_EMIT,       1'b1};
                default:       w = '{OP_NOP,        COND_NEVER,       ST_WAIT,       1'b1};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- design/ses_if.sv -----
// Channel interfaces: input items, result items and register writes.
interface ses_in_if;
    logic                                valid;
    logic                                ready;
    logic        [ses_pkg::POS_W-1:0]   position_count;
    logic        [ses_pkg::PULSE_W-1:0] pulse_count;
    logic signed [ses_pkg::SPEED_W-1:0] target_speed;

    modport source (output valid, position_count, pulse_count, target_speed, input ready);
    modport sink   (input valid, position_count, pulse_count, target_speed, output ready);
endinterface

interface ses_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ses_pkg::SPEED_W-1:0] speed;
    logic                                timed_mode;
    logic                                zero_pulse;

    modport source (output valid, speed, timed_mode, zero_pulse, input ready);
    modport sink   (input valid, speed, timed_mode, zero_pulse, output ready);
endinterface

interface ses_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ses_pkg::CFG_IDX_W-1:0]      index;
    logic [ses_pkg::CFG_DAT_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ses_divider.sv -----
// Shared restoring divider, two quotient bits per cycle.
module ses_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  ses_pkg::div_len_t                  len,
    input  logic [ses_pkg::DIV_W-1:0]          dividend,
    input  logic [ses_pkg::DIVISOR_W-1:0]      divisor,
    output logic                               busy,
    output logic [ses_pkg::DIV_W-1:0]          quotient
);

    localparam int DW = ses_pkg::DIV_W;
    localparam int VW = ses_pkg::DIVISOR_W;
    localparam int CW = ses_pkg::DIV_CNT_W;

    logic [DW-1:0] work_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvsr_reg;
    logic [CW-1:0] count_reg;

    logic [DW-1:0] align;
    logic [CW-1:0] steps;
    logic [VW:0]   r1;
    logic [VW:0]   r2;
    logic          ge1;
    logic          ge2;
    logic [VW-1:0] rem1;
    logic [VW-1:0] rem2;

    // Left-align the dividend so its top bit enters first
    always_comb
    begin
        case (len)
            ses_pkg::DIV_LEN_32:
            begin
                align = dividend << (DW - 32);
                steps = CW'(16);
            end
            ses_pkg::DIV_LEN_36:
            begin
                align = dividend << (DW - 36);
                steps = CW'(18);
            end
            default:
            begin
                align = dividend;
                steps = CW'(DW / 2);
            end
        endcase
    end

    always_comb
    begin
        r1   = {rem_reg, work_reg[DW-1]};
        ge1  = r1 >= {1'b0, dvsr_reg};
        rem1 = ge1 ? VW'(r1 - {1'b0, dvsr_reg}) : VW'(r1);
        r2   = {rem1, work_reg[DW-2]};
        ge2  = r2 >= {1'b0, dvsr_reg};
        rem2 = ge2 ? VW'(r2 - {1'b0, dvsr_reg}) : VW'(r2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= steps;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= align;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            work_reg <= {work_reg[DW-3:0], ge1, ge2};
            rem_reg  <= rem2;
        end
    end

    // Busy until the cycle that retires the last pair of bits
    assign busy     = count_reg > CW'(1);
    assign quotient = work_reg;

endmodule

// ----- design/ses_sequencer.sv -----
// Step counter and control store of the estimator.
module ses_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  ses_pkg::status_t status,
    output ses_pkg::ucode_t  ctl
);

    logic [ses_pkg::STEP_W-1:0] pc_reg;
    logic [ses_pkg::STEP_W-1:0] pc_next;
    logic                       taken;

    assign ctl = ses_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (ctl.cond)
            ses_pkg::COND_NO_INPUT:    taken = !status.in_valid;
            ses_pkg::COND_SKIP_FACTOR: taken = status.skip_factor;
            ses_pkg::COND_DIV_BUSY:    taken = status.div_busy;
            ses_pkg::COND_OUT_BLOCKED: taken = status.out_blocked;
            default:                   taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (taken)
        begin
            pc_next = ctl.target;
        end
        else if (ctl.last)
        begin
            pc_next = ses_pkg::ST_WAIT;
        end
        else
        begin
            pc_next = pc_reg + ses_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ses_pkg::ST_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- design/encoder_speed_estimator_top.sv -----
// Encoder speed estimator: datapath, registers and result buffer around the sequencer.
//
//  channel  direction  carries
//  -------  ---------  ---------------------------------------------------
//  item     in         position_count, pulse_count, target_speed
//  result   out        speed, timed_mode, zero_pulse
//  cfg      in         index, data (register write, always ready)
//
// An item in timed mode takes three passes of the shared divider, at two
// quotient bits per cycle: raw factor, smoothed factor and speed.
// In fixed mode or with a zero pulse count only the speed division runs.
// Reset puts the sequencer at its wait step, the estimator in timed mode with
// zero state and counts_per_rev at 4096.
// A result waits in an output register; the sequencer holds at its last step
// only while that register is still full and result.ready is low.
module encoder_speed_estimator_top #(
    parameter int COUNT_BITS = ses_pkg::COUNT_BITS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    ses_in_if.sink    item,
    ses_out_if.source result,
    ses_cfg_if.sink   cfg
);

    localparam int EXT_W  = (COUNT_BITS > ses_pkg::POS_W) ? COUNT_BITS : ses_pkg::POS_W;
    localparam int DIFF_W = COUNT_BITS + 1;
    localparam int CMP_W  = (DIFF_W > ses_pkg::WIN_W) ? DIFF_W : ses_pkg::WIN_W;
    localparam int KW     = ses_pkg::KEPT_W;
    localparam int SW     = ses_pkg::SPEED_W;
    localparam int GW     = ses_pkg::GAIN_W;
    localparam int PW     = ses_pkg::PROD_W;
    localparam int DW     = ses_pkg::DIV_W;
    localparam int FW     = ses_pkg::FNUM_W;

    localparam logic [DW-1:0] SAT_NEG_MAG = DW'(64'h8000_0000);
    localparam logic [DW-1:0] SAT_POS_MAG = DW'(64'h7FFF_FFFF);

    // Configuration
    logic [ses_pkg::CPR_W-1:0]    cpr_reg;
    logic [GW-1:0]                fixed_gain_reg;
    logic [GW-1:0]                timed_gain_reg;
    logic [ses_pkg::THRESH_W-1:0] high_thr_reg;
    logic [ses_pkg::THRESH_W-1:0] low_thr_reg;

    // Estimator state
    logic [COUNT_BITS-1:0] last_count_reg;
    logic signed [KW-1:0]  kept_reg;
    logic signed [SW-1:0]  speed_reg;
    logic [GW-1:0]         factor_reg;
    logic                  use_timing_reg;

    // Per-item working registers
    logic [ses_pkg::PULSE_W-1:0] pulses_reg;
    logic [SW-1:0]               mag_reg;
    logic                        timed_reg;
    logic                        zero_reg;
    logic signed [PW-1:0]        prod_reg;
    logic                        neg_reg;

    // Result buffer
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_speed_reg;
    logic                 out_timed_reg;
    logic                 out_zero_reg;

    ses_pkg::ucode_t  ctl;
    ses_pkg::status_t status;

    logic                          accept;
    logic [EXT_W-1:0]              pos_wide;
    logic [COUNT_BITS-1:0]         now;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             diff_abs;
    logic                          window_ok;
    logic [SW-1:0]                 tgt_raw;
    logic [SW-1:0]                 tgt_mag;
    logic [FW-1:0]                 fnum;
    logic [GW-1:0]                 gain_sel;
    logic signed [PW-1:0]          snum;
    logic [PW-1:0]                 snum_mag;
    logic [SW-1:0]                 speed_next;
    logic                          out_blocked;
    logic                          emit;

    logic                          div_start;
    ses_pkg::div_len_t             div_len;
    logic [DW-1:0]                 div_dividend;
    logic [ses_pkg::DIVISOR_W-1:0] div_divisor;
    logic                          div_busy;
    logic [DW-1:0]                 div_q;

    ses_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    ses_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .len      (div_len),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign item.ready = (ctl.op == ses_pkg::OP_LOAD);
    assign accept     = item.ready && item.valid;
    assign cfg.ready  = 1'b1;

    assign out_blocked = out_valid_reg && !result.ready;
    assign emit        = (ctl.op == ses_pkg::OP_EMIT) && !out_blocked;

    assign status.in_valid    = item.valid;
    assign status.skip_factor = !timed_reg || zero_reg;
    assign status.div_busy    = div_busy;
    assign status.out_blocked = out_blocked;

    // Count difference and quarter-revolution window
    assign pos_wide  = EXT_W'(item.position_count);
    assign now       = pos_wide[COUNT_BITS-1:0];
    assign diff      = $signed({1'b0, now}) - $signed({1'b0, last_count_reg});
    assign diff_abs  = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
    assign window_ok = CMP_W'(diff_abs) < CMP_W'(cpr_reg[ses_pkg::CPR_W-1:2]);

    assign tgt_raw = item.target_speed;
    assign tgt_mag = tgt_raw[SW-1] ? (~tgt_raw + SW'(1)) : tgt_raw;

    // raw + 9 * factor + 5
    assign fnum = FW'(div_q[GW-1:0]) + FW'(factor_reg) + (FW'(factor_reg) << 3)
                + FW'(ses_pkg::ROUND_HALF);

    assign gain_sel = timed_reg ? factor_reg : fixed_gain_reg;

    // difference * gain + 9 * speed, rounded away from zero on the magnitude
    assign snum     = prod_reg + PW'(speed_reg) + (PW'(speed_reg) <<< 3);
    assign snum_mag = snum[PW-1] ? $unsigned(-snum) : $unsigned(snum);

    always_comb
    begin
        if (neg_reg)
        begin
            speed_next = (div_q > SAT_NEG_MAG) ? SW'(32'h8000_0000)
                                               : (SW'(0) - div_q[SW-1:0]);
        end
        else
        begin
            speed_next = (div_q > SAT_POS_MAG) ? SW'(32'h7FFF_FFFF) : div_q[SW-1:0];
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_len      = ses_pkg::DIV_LEN_52;
        div_dividend = DW'(snum_mag) + DW'(ses_pkg::ROUND_HALF);
        div_divisor  = ses_pkg::DIVISOR_W'(ses_pkg::SMOOTH_DIV);
        case (ctl.op)
            ses_pkg::OP_DIV_RAW:
            begin
                div_start    = 1'b1;
                div_len      = ses_pkg::DIV_LEN_32;
                div_dividend = DW'(timed_gain_reg);
                div_divisor  = pulses_reg;
            end
            ses_pkg::OP_FACTOR_NUM:
            begin
                div_start    = 1'b1;
                div_len      = ses_pkg::DIV_LEN_36;
                div_dividend = DW'(fnum);
            end
            ses_pkg::OP_SPEED_NUM:
            begin
                div_start    = 1'b1;
            end
            default:
            begin
                div_start    = 1'b0;
            end
        endcase
    end

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg        <= ses_pkg::CPR_RESET;
            fixed_gain_reg <= '0;
            timed_gain_reg <= '0;
            high_thr_reg   <= '0;
            low_thr_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ses_pkg::REG_COUNTS_PER_REV: cpr_reg        <= cfg.data[ses_pkg::CPR_W-1:0];
                ses_pkg::REG_FIXED_GAIN:     fixed_gain_reg <= cfg.data[GW-1:0];
                ses_pkg::REG_TIMED_GAIN:     timed_gain_reg <= cfg.data[GW-1:0];
                ses_pkg::REG_HIGH_THRESHOLD: high_thr_reg   <= cfg.data[ses_pkg::THRESH_W-1:0];
                ses_pkg::REG_LOW_THRESHOLD:  low_thr_reg    <= cfg.data[ses_pkg::THRESH_W-1:0];
                default:                     cpr_reg        <= cpr_reg;
            endcase
        end
    end

    // Estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            kept_reg       <= '0;
            speed_reg      <= '0;
            factor_reg     <= '0;
            use_timing_reg <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                last_count_reg <= now;
                if (window_ok)
                begin
                    kept_reg <= KW'(diff);
                end
            end
            if (ctl.op == ses_pkg::OP_FACTOR_SET)
            begin
                factor_reg <= div_q[GW-1:0];
            end
            if (ctl.op == ses_pkg::OP_SPEED_SET)
            begin
                speed_reg <= speed_next;
                // Hysteresis on the target magnitude
                if (timed_reg)
                begin
                    if (mag_reg > SW'(high_thr_reg))
                    begin
                        use_timing_reg <= 1'b0;
                    end
                end
                else if (mag_reg < SW'(low_thr_reg))
                begin
                    use_timing_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pulses_reg <= item.pulse_count;
            mag_reg    <= tgt_mag;
            timed_reg  <= use_timing_reg;
            zero_reg   <= use_timing_reg && (item.pulse_count == '0);
        end
        if (ctl.op == ses_pkg::OP_MUL)
        begin
            prod_reg <= PW'(kept_reg * $signed({1'b0, gain_sel}));
        end
        if (ctl.op == ses_pkg::OP_SPEED_NUM)
        begin
            neg_reg <= snum[PW-1];
        end
        if (emit)
        begin
            out_speed_reg <= speed_reg;
            out_timed_reg <= timed_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.speed      = out_speed_reg;
    assign result.timed_mode = out_timed_reg;
    assign result.zero_pulse = out_zero_reg;

    // Checks
    a_zero_only_timed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_zero_reg && !out_timed_reg))
        else $error("zero pulse flag reported in fixed mode");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("second item taken while one is in work");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_mode_change_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(use_timing_reg) |-> $past(ctl.op == ses_pkg::OP_SPEED_SET))
        else $error("mode changed outside the speed update step");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.op == ses_pkg::OP_EMIT))
        else $error("result raised outside the emit step");

endmodule

// ----- bench/ses_tick_checker.sv -----
// Checker for the encoder speed estimator: predicts every tick's result and compares it.
`timescale 1ns / 1ps
module ses_tick_checker
    import ses_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    ses_in_if    item,
    ses_out_if   result,
    ses_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    localparam longint SPEED_MAX = (longint'(1) << (SPEED_W - 1)) - 1;
    localparam longint SPEED_MIN = -(longint'(1) << (SPEED_W - 1));

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      timed_mode;
        logic                      zero_pulse;
    } tick_result_t;

    // Register copies
    logic [CPR_W-1:0]    counts_per_rev;
    logic [GAIN_W-1:0]   fixed_gain;
    logic [GAIN_W-1:0]   timed_gain;
    logic [THRESH_W-1:0] high_threshold;
    logic [THRESH_W-1:0] low_threshold;

    // Estimator state
    logic [POS_W-1:0]          prev_count;
    logic signed [POS_W:0]     kept_diff;
    logic signed [SPEED_W-1:0] speed_est;
    logic [GAIN_W-1:0]         factor;
    logic                      timed_sel;

    tick_result_t awaited_ticks[$];
    tick_result_t want;
    int           fail_total;

    function automatic tick_result_t advance_estimator(
        input logic [POS_W-1:0]          pos,
        input logic [PULSE_W-1:0]        pulses,
        input logic signed [SPEED_W-1:0] target
    );
        tick_result_t r;
        longint       now;
        longint       diff;
        longint       window;
        longint       mag;
        longint       raw;
        longint       gain;
        longint       num;
        longint       rounded;
        begin
            now    = longint'(pos) & ((longint'(1) << COUNT_BITS) - 1);
            diff   = now - longint'(prev_count);
            window = longint'(counts_per_rev) / 4;
            // Reuse the last good difference when the jump looks like a wrap glitch
            if (diff > -window && diff < window)
                kept_diff = diff[POS_W:0];
            prev_count = now[POS_W-1:0];
            mag = (target < 0) ? -longint'(target) : longint'(target);

            r.timed_mode = timed_sel;
            r.zero_pulse = 1'b0;
            if (timed_sel)
            begin
                if (pulses == '0)
                    r.zero_pulse = 1'b1;
                else
                begin
                    raw    = longint'(timed_gain) / longint'(pulses);
                    factor = GAIN_W'((raw + (SMOOTH_DIV - 1) * longint'(factor) + ROUND_HALF)
                                     / SMOOTH_DIV);
                end
                gain = longint'(factor);
                if (mag > longint'(high_threshold))
                    timed_sel = 1'b0;
            end
            else
            begin
                gain = longint'(fixed_gain);
                if (mag < longint'(low_threshold))
                    timed_sel = 1'b1;
            end

            num     = longint'(kept_diff) * gain + (SMOOTH_DIV - 1) * longint'(speed_est);
            rounded = (num >= 0 ? num + ROUND_HALF : num - ROUND_HALF) / SMOOTH_DIV;
            if (rounded > SPEED_MAX)
                rounded = SPEED_MAX;
            if (rounded < SPEED_MIN)
                rounded = SPEED_MIN;
            speed_est = rounded[SPEED_W-1:0];
            r.speed   = speed_est;
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_per_rev = CPR_RESET;
            fixed_gain     = '0;
            timed_gain     = '0;
            high_threshold = '0;
            low_threshold  = '0;
            prev_count     = '0;
            kept_diff      = '0;
            speed_est      = '0;
            factor         = '0;
            timed_sel      = 1'b1;
            awaited_ticks.delete();
            fail_total     = 0;
            mismatches    <= 0;
            outstanding   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_COUNTS_PER_REV: counts_per_rev = cfg.data[CPR_W-1:0];
                    REG_FIXED_GAIN:     fixed_gain     = cfg.data[GAIN_W-1:0];
                    REG_TIMED_GAIN:     timed_gain     = cfg.data[GAIN_W-1:0];
                    REG_HIGH_THRESHOLD: high_threshold = cfg.data[THRESH_W-1:0];
                    REG_LOW_THRESHOLD:  low_threshold  = cfg.data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            // Compare before queueing: a result never belongs to the item taken this edge
            if (result.valid && result.ready)
            begin
                if (awaited_ticks.size() == 0)
                begin
                    $error("unexpected result: speed %0d timed_mode %0b zero_pulse %0b",
                           result.speed, result.timed_mode, result.zero_pulse);
                    fail_total++;
                end
                else
                begin
                    want = awaited_ticks.pop_front();
                    if (result.speed !== want.speed)
                    begin
                        $error("speed: expected %0d, actual %0d", want.speed, result.speed);
                        fail_total++;
                    end
                    if (result.timed_mode !== want.timed_mode)
                    begin
                        $error("timed_mode: expected %0b, actual %0b",
                               want.timed_mode, result.timed_mode);
                        fail_total++;
                    end
                    if (result.zero_pulse !== want.zero_pulse)
                    begin
                        $error("zero_pulse: expected %0b, actual %0b",
                               want.zero_pulse, result.zero_pulse);
                        fail_total++;
                    end
                end
            end

            if (item.valid && item.ready)
                awaited_ticks.push_back(advance_estimator(item.position_count, item.pulse_count,
                                                          item.target_speed));

            mismatches  <= fail_total;
            outstanding <= awaited_ticks.size();
        end
    end

endmodule

// ----- bench/encoder_speed_estimator_top_tb.sv -----
// Stimulus, handshake idling and final verdict for the encoder speed estimator.
`timescale 1ns / 1ps
module encoder_speed_estimator_top_tb;
    import ses_pkg::*;

    localparam int IDLE_MAX      = 10;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int CFG_WRITES    = REG_LOW_THRESHOLD + 2;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;

    ses_in_if  item_ch ();
    ses_out_if result_ch ();
    ses_cfg_if cfg_ch ();

    encoder_speed_estimator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ses_tick_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Write all five registers, then one unused index that must be ignored
    task automatic configure(input logic [CFG_DAT_W-1:0] cpr, fgain, tgain, hi, lo);
        logic [CFG_DAT_W-1:0] values [CFG_WRITES];
        values = '{cpr, fgain, tgain, hi, lo, $urandom};
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < CFG_WRITES; i++)
        begin
            if (i <= REG_LOW_THRESHOLD)
                cfg_ch.index <= CFG_IDX_W'(i);
            else
                cfg_ch.index <= CFG_IDX_W'($urandom_range(REG_LOW_THRESHOLD + 1,
                                                          2 ** CFG_IDX_W - 1));
            cfg_ch.data <= values[i];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [POS_W-1:0] pos, input logic [PULSE_W-1:0] pulses,
                             input logic signed [SPEED_W-1:0] target);
        int gap;
        gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.position_count <= pos;
        item_ch.pulse_count    <= pulses;
        item_ch.target_speed   <= target;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Hold off until every outstanding tick has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles before each transaction
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [CFG_DAT_W-1:0]      cpr_data;
        logic [CFG_DAT_W-1:0]      fg_data;
        logic [CFG_DAT_W-1:0]      tg_data;
        logic [CFG_DAT_W-1:0]      hi_data;
        logic [CFG_DAT_W-1:0]      lo_data;
        logic [THRESH_W-1:0]       hi_now;
        logic [THRESH_W-1:0]       lo_now;
        logic [POS_W-1:0]          pos;
        logic [PULSE_W-1:0]        pulses;
        logic signed [SPEED_W-1:0] target;
        longint                    mag;
        int                        win;

        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.position_count <= '0;
        item_ch.pulse_count    <= '0;
        item_ch.target_speed   <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= '0;
        cfg_ch.data            <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset, including a zero pulse count and a rejected jump
        send_tick(16'd100, 16'd50, '0);
        send_tick(16'd5000, 16'd0, '0);
        drain();

        configure(32'd4096, 32'h0001_8000, 32'h0100_0000, 32'h0010_0000, 32'h0008_0000);
        send_tick(16'd5010, 16'd1, '0);
        send_tick(16'd5020, 16'hFFFF, 32'sh0000_FFFF);
        send_tick(16'd6043, 16'd0, '0);          // largest accepted step
        send_tick(16'd7067, 16'd100, '0);        // one past the window: reuse last step
        send_tick(16'd6044, 16'd100, '0);        // largest accepted step backwards
        send_tick(16'd5020, 16'd100, '0);
        send_tick(16'hFFFF, 16'd200, '0);
        send_tick(16'd0, 16'd200, '0);           // counter wrap, not taken modulo
        send_tick(16'd0, 16'd300, 32'sh0010_0000);   // at the high threshold: stay timed
        send_tick(16'd5, 16'd300, 32'sh0010_0001);   // above it: fixed next
        send_tick(16'd10, 16'd0, 32'sh8000_0000);    // fixed, zero pulse not flagged
        send_tick(16'd15, 16'd300, 32'sh0008_0000);  // at the low threshold: stay fixed
        send_tick(16'd20, 16'd300, 32'shFFF8_0001);  // below it: timed next
        send_tick(16'd25, 16'd1000, 32'sh8000_0000); // most negative target
        send_tick(16'd30, 16'd1000, 32'sh7FFF_FFFF);
        send_tick(16'd35, 16'd1000, 32'shFFFF_FFFF);
        send_tick(16'd40, 16'hFFFF, '0);
        drain();

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_tick(16'd16422, 16'd1, 32'sh7FFF_FFFF);  // drive the speed into saturation
        send_tick(16'd40, 16'd1, 32'sh7FFF_FFFF);
        send_tick(16'd16423, 16'd1, '0);
        drain();

        // Window too small to accept any difference
        configure(32'd3, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_tick(16'd40, 16'd2, '0);
        send_tick(16'd41, 16'd2, 32'sh0000_0001);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cpr_data = 32'd4096;
                    fg_data  = $urandom_range(0, 32'h0010_0000);
                    tg_data  = $urandom_range(32'h0001_0000, 32'h1000_0000);
                    lo_data  = $urandom_range(0, 32'h0100_0000);
                    hi_data  = lo_data + $urandom_range(0, 32'h0100_0000);
                end
                1:
                begin
                    cpr_data = 32'd4;
                    fg_data  = $urandom;
                    tg_data  = $urandom;
                    hi_data  = $urandom_range(0, 32'h0100_0000);
                    lo_data  = $urandom_range(0, 32'h0100_0000);
                end
                2:
                begin
                    cpr_data = 32'h0000_FFFF;
                    fg_data  = 32'hFFFF_FFFF;
                    tg_data  = 32'hFFFF_FFFF;
                    hi_data  = $urandom_range(0, 32'h0400_0000);
                    lo_data  = $urandom_range(0, 32'h0400_0000);
                end
                3:
                begin
                    cpr_data = $urandom_range(0, 3);
                    fg_data  = $urandom;
                    tg_data  = $urandom;
                    hi_data  = $urandom;
                    lo_data  = $urandom;
                end
                4:
                begin
                    cpr_data = $urandom_range(4, 32'hFFFF);
                    fg_data  = 32'd0;
                    tg_data  = 32'd0;
                    hi_data  = 32'd0;
                    lo_data  = 32'h7FFF_FFFF;
                end
                5:
                begin
                    cpr_data = $urandom_range(4, 2048);
                    fg_data  = $urandom_range(0, 32'h0004_0000);
                    tg_data  = $urandom;
                    hi_data  = 32'h7FFF_FFFF;
                    lo_data  = 32'h7FFF_FFFF;
                end
                default:
                begin
                    cpr_data = $urandom;
                    fg_data  = $urandom;
                    tg_data  = $urandom;
                    hi_data  = $urandom;
                    lo_data  = $urandom;
                end
            endcase
            configure(cpr_data, fg_data, tg_data, hi_data, lo_data);
            win    = int'(cpr_data[CPR_W-1:0]) / 4;
            hi_now = hi_data[THRESH_W-1:0];
            lo_now = lo_data[THRESH_W-1:0];

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);

                // Mostly steady rotation inside the window, now and then a glitch
                case ($urandom_range(0, 15))
                    0:       pos = $urandom;
                    1:       pos = pos + POS_W'(win + $urandom_range(0, 64));
                    2:       pos = pos - POS_W'(win + $urandom_range(0, 64));
                    default: pos = pos + POS_W'(int'($urandom_range(0, 2 * win + 2)) - win - 1);
                endcase

                case ($urandom_range(0, 9))
                    0:       pulses = '0;
                    1:       pulses = $urandom;
                    default: pulses = $urandom_range(1, 4000);
                endcase

                // Keep the magnitude near the thresholds so the mode keeps switching
                case ($urandom_range(0, 4))
                    0:       mag = longint'($urandom);
                    1:       mag = longint'(hi_now) + $urandom_range(0, 2) - 1;
                    2:       mag = longint'(lo_now) + $urandom_range(0, 2) - 1;
                    3:       mag = longint'($urandom_range(0, hi_now));
                    default: mag = longint'($urandom_range(0, lo_now));
                endcase
                if ($urandom_range(0, 1) == 1)
                    mag = -mag;
                target = SPEED_W'(mag);

                send_tick(pos, pulses, target);
            end
            drain();
        end

        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
